>>> rtl/udff_pkg.sv
// Shared types and constants for the unsigned decimal field formatter.
package udff_pkg;

   localparam int VALUE_W = 32;
   localparam int FIELD_W = 6;
   localparam int CHAR_W  = 8;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CONVERT,
      FRONT_COUNT,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SETUP,
      BACK_EMIT
   } back_state_type;

   // Layout of one formatted number as it travels from front to back.
   typedef struct packed {
      logic [FIELD_W-1:0] nlen;       // digit string length incl. precision zeros
      logic [FIELD_W-1:0] width;      // saturated field width
      logic               zero_fill;  // '0' padding on the left
      logic               left_align; // digits first, spaces after
   } fmt_type;

endpackage

>>> rtl/udff_if.sv
// Request and response channel interfaces for the decimal field formatter.
interface udff_req_if;
   logic                          valid;
   logic                          ready;
   logic [udff_pkg::VALUE_W-1:0]  value;
   logic [udff_pkg::FIELD_W-1:0]  field_width;
   logic [udff_pkg::FIELD_W-1:0]  precision;
   logic                          has_precision;
   logic                          zero_pad;
   logic                          left_align;

   modport source (
      output valid, value, field_width, precision, has_precision, zero_pad, left_align,
      input  ready
   );
   modport sink (
      input  valid, value, field_width, precision, has_precision, zero_pad, left_align,
      output ready
   );
endinterface

interface udff_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [udff_pkg::CHAR_W-1:0]   char_code;
   logic                          char_valid;
   logic                          last;
   logic [udff_pkg::FIELD_W-1:0]  total_count;

   modport source (
      output valid, char_code, char_valid, last, total_count,
      input  ready
   );
   modport sink (
      input  valid, char_code, char_valid, last, total_count,
      output ready
   );
endinterface

>>> rtl/udff_front.sv
// Front end: takes a request, converts the value to BCD and sizes the digit string.
module udff_front #(
   parameter int MAX_FIELD  = 63,
   parameter int MAX_DIGITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   udff_req_if.sink                      req_ch,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [4*MAX_DIGITS-1:0]       push_digits,
   output udff_pkg::fmt_type             push_fmt
);

   localparam int BCD_W  = 4 * MAX_DIGITS;
   localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
   localparam int BIT_W  = $clog2(udff_pkg::VALUE_W);
   localparam logic [udff_pkg::FIELD_W-1:0] FIELD_CAP = udff_pkg::FIELD_W'(MAX_FIELD);

   udff_pkg::front_state_type state_ff, state_in;

   logic [udff_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [BCD_W-1:0]             bcd_ff, bcd_in;
   logic                         ovf_ff, ovf_in;
   logic [BIT_W-1:0]             bit_cnt_ff, bit_cnt_in;
   logic [NDIG_W-1:0]            ndig_ff, ndig_in;
   logic [udff_pkg::FIELD_W-1:0] width_ff, width_in;
   logic [udff_pkg::FIELD_W-1:0] prec_ff, prec_in;
   logic                         dot_ff, dot_in;
   logic                         zero_ff, zero_in;
   logic                         left_ff, left_in;

   logic [BCD_W-1:0]             bcd_adj;
   logic [NDIG_W-1:0]            top_digit;
   logic                         value_zero;
   logic [udff_pkg::FIELD_W-1:0] ndig_ext;

   // Double-dabble correction: any digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] > 4'd4) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Position of the most significant nonzero digit, plus one.
   always_comb begin
      top_digit = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            top_digit = NDIG_W'(i + 1);
         end
      end
   end

   assign value_zero = !ovf_ff && (bcd_ff == '0);
   assign ndig_ext   = udff_pkg::FIELD_W'(ndig_ff);

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      bcd_in     = bcd_ff;
      ovf_in     = ovf_ff;
      bit_cnt_in = bit_cnt_ff;
      ndig_in    = ndig_ff;
      width_in   = width_ff;
      prec_in    = prec_ff;
      dot_in     = dot_ff;
      zero_in    = zero_ff;
      left_in    = left_ff;
      req_ch.ready = 1'b0;
      push_valid   = 1'b0;

      case (state_ff)
         udff_pkg::FRONT_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               value_in   = req_ch.value;
               bcd_in     = '0;
               ovf_in     = 1'b0;
               bit_cnt_in = '0;
               width_in   = (req_ch.field_width > FIELD_CAP) ? FIELD_CAP : req_ch.field_width;
               prec_in    = (req_ch.precision > FIELD_CAP) ? FIELD_CAP : req_ch.precision;
               dot_in     = req_ch.has_precision;
               zero_in    = req_ch.zero_pad;
               left_in    = req_ch.left_align;
               state_in   = udff_pkg::FRONT_CONVERT;
            end
         end
         udff_pkg::FRONT_CONVERT: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], value_ff[udff_pkg::VALUE_W-1]};
            ovf_in     = ovf_ff | bcd_adj[BCD_W-1];  // digits above the kept ones
            value_in   = {value_ff[udff_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_W'(udff_pkg::VALUE_W - 1)) begin
               state_in = udff_pkg::FRONT_COUNT;
            end
         end
         udff_pkg::FRONT_COUNT: begin
            if (ovf_ff) begin
               ndig_in = NDIG_W'(MAX_DIGITS);
            end else if (top_digit == '0) begin
               ndig_in = NDIG_W'(1);
            end else begin
               ndig_in = top_digit;
            end
            state_in = udff_pkg::FRONT_PUSH;
         end
         udff_pkg::FRONT_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = udff_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = udff_pkg::FRONT_IDLE;
         end
      endcase
   end

   always_comb begin
      push_digits         = bcd_ff;
      push_fmt.width      = width_ff;
      push_fmt.zero_fill  = zero_ff && !dot_ff;
      push_fmt.left_align = left_ff;
      // explicit zero precision on a zero value prints no digits
      if (dot_ff && (prec_ff == '0) && value_zero) begin
         push_fmt.nlen = '0;
      end else if (dot_ff && (prec_ff > ndig_ext)) begin
         push_fmt.nlen = prec_ff;
      end else begin
         push_fmt.nlen = ndig_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= udff_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      bcd_ff     <= bcd_in;
      ovf_ff     <= ovf_in;
      bit_cnt_ff <= bit_cnt_in;
      ndig_ff    <= ndig_in;
      width_ff   <= width_in;
      prec_ff    <= prec_in;
      dot_ff     <= dot_in;
      zero_ff    <= zero_in;
      left_ff    <= left_in;
   end

endmodule

>>> rtl/udff_queue.sv
// Two-entry queue between the conversion front end and the character back end.
module udff_queue #(
   parameter int WIDTH = 54
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/udff_back.sv
// Back end: lays out padding and digits and sends one character per response.
module udff_back #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  logic [4*MAX_DIGITS-1:0]       pop_digits,
   input  udff_pkg::fmt_type             pop_fmt,
   udff_rsp_if.source                    rsp_ch
);

   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam int FW    = udff_pkg::FIELD_W;

   udff_pkg::back_state_type state_ff, state_in;

   logic [BCD_W-1:0]  digits_ff, digits_in;
   udff_pkg::fmt_type fmt_ff, fmt_in;
   logic [FW-1:0]     total_ff, total_in;
   logic [FW-1:0]     start_ff, start_in;
   logic [FW-1:0]     end_ff, end_in;
   logic [FW-1:0]     pos_ff, pos_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [udff_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                        cvalid_ff, cvalid_in;
   logic                        last_ff, last_in;
   logic [FW-1:0]               count_ff, count_in;

   logic [FW-1:0]               pad;
   logic [FW-1:0]               idx;
   logic [3:0]                  nib;
   logic                        in_num;
   logic                        is_empty;
   logic                        is_last;
   logic                        slot_free;
   logic [udff_pkg::CHAR_W-1:0] ch;

   assign pad = (fmt_ff.width > fmt_ff.nlen) ? (fmt_ff.width - fmt_ff.nlen) : '0;

   // idx counts digit places from the least significant one; beyond the kept digits the digit reads as '0'
   assign in_num = (pos_ff >= start_ff) && (pos_ff < end_ff);
   assign idx    = end_ff - pos_ff - FW'(1);

   always_comb begin
      nib = 4'd0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (idx == FW'(i)) begin
            nib = digits_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      if (in_num) begin
         ch = udff_pkg::CH_ZERO + {4'd0, nib};
      end else if (fmt_ff.zero_fill) begin
         ch = udff_pkg::CH_ZERO;
      end else begin
         ch = udff_pkg::CH_SPACE;
      end
   end

   assign is_empty  = (total_ff == '0);
   assign is_last   = is_empty || ({1'b0, pos_ff} + (FW+1)'(1) == {1'b0, total_ff});
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      fmt_in       = fmt_ff;
      total_in     = total_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      char_in      = char_ff;
      cvalid_in    = cvalid_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      pop_ready    = 1'b0;

      case (state_ff)
         udff_pkg::BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               digits_in = pop_digits;
               fmt_in    = pop_fmt;
               state_in  = udff_pkg::BACK_SETUP;
            end
         end
         udff_pkg::BACK_SETUP: begin
            total_in = fmt_ff.nlen + pad;
            if (fmt_ff.zero_fill || !fmt_ff.left_align) begin
               start_in = pad;
               end_in   = pad + fmt_ff.nlen;
            end else begin
               start_in = '0;
               end_in   = fmt_ff.nlen;
            end
            pos_in   = '0;
            state_in = udff_pkg::BACK_EMIT;
         end
         udff_pkg::BACK_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               char_in      = is_empty ? udff_pkg::CH_NONE : ch;
               cvalid_in    = !is_empty;
               last_in      = is_last;
               count_in     = is_last ? total_ff : '0;
               pos_in       = pos_ff + FW'(1);
               if (is_last) begin
                  state_in = udff_pkg::BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = udff_pkg::BACK_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.char_code   = char_ff;
   assign rsp_ch.char_valid  = cvalid_ff;
   assign rsp_ch.last        = last_ff;
   assign rsp_ch.total_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= udff_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      fmt_ff    <= fmt_in;
      total_ff  <= total_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      pos_ff    <= pos_in;
      char_ff   <= char_in;
      cvalid_ff <= cvalid_in;
      last_ff   <= last_in;
      count_ff  <= count_in;
   end

endmodule

>>> rtl/unsigned_decimal_field_formatter.sv
// Formats a 32-bit unsigned value as printf-style decimal text, one ASCII character per
// response, the last one flagged and carrying the character count (an empty field gives a
// single response with char_valid low). For every request the front end accepts it, runs
// 32 one-bit double-dabble steps, counts digits and pushes the result into a two-entry
// queue; it takes no new request until that push. The back end pops an entry, works out
// the layout and then emits one character per cycle while the response side is ready, at
// least one response per request. Front and back overlap; back pressure on the response
// side can fill the queue and then stall the front end. Width and precision saturate at
// MAX_FIELD; only the lowest MAX_DIGITS decimal digits of the value are kept.
module unsigned_decimal_field_formatter #(
   parameter int MAX_FIELD  = 63,
   parameter int MAX_DIGITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   udff_req_if.sink   req_ch,
   udff_rsp_if.source rsp_ch
);

   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam int Q_W   = BCD_W + $bits(udff_pkg::fmt_type);

   logic              push_valid, push_ready;
   logic [BCD_W-1:0]  push_digits;
   udff_pkg::fmt_type push_fmt;
   logic              pop_valid, pop_ready;
   logic [Q_W-1:0]    pop_data;
   logic [BCD_W-1:0]  pop_digits;
   udff_pkg::fmt_type pop_fmt;

   assign {pop_digits, pop_fmt} = pop_data;

   udff_front #(
      .MAX_FIELD  (MAX_FIELD),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_digits (push_digits),
      .push_fmt    (push_fmt)
   );

   udff_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_digits, push_fmt}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   udff_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_digits (pop_digits),
      .pop_fmt    (pop_fmt),
      .rsp_ch     (rsp_ch)
   );

endmodule

>>> rtl/udff_checker.sv
// Port-level checks on the formatter's response stream, bound to the top level.
module udff_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [udff_pkg::CHAR_W-1:0]   rsp_char_code,
   input logic                          rsp_char_valid,
   input logic                          rsp_last,
   input logic [udff_pkg::FIELD_W-1:0]  rsp_total_count
);

   logic [udff_pkg::FIELD_W-1:0] chars_ff, chars_in;
   logic                         rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   // characters already delivered for the request in flight
   always_comb begin
      chars_in = chars_ff;
      if (rsp_fire) begin
         chars_in = rsp_last ? '0 : chars_ff + udff_pkg::FIELD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= '0;
      end else begin
         chars_ff <= chars_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code)
         && $stable(rsp_char_valid) && $stable(rsp_last) && $stable(rsp_total_count))
      else $error("response changed while stalled");

   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_last && (rsp_total_count == '0)
         && (rsp_char_code == udff_pkg::CH_NONE) && (chars_ff == '0))
      else $error("empty-field marker malformed");

   a_count_zero_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_char_valid && (rsp_total_count == '0))
      else $error("non-final response carries a count");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_last && rsp_char_valid
         |-> rsp_total_count == chars_ff + udff_pkg::FIELD_W'(1))
      else $error("total count differs from characters delivered");

endmodule

bind unsigned_decimal_field_formatter udff_checker u_udff_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_char_code   (rsp_ch.char_code),
   .rsp_char_valid  (rsp_ch.char_valid),
   .rsp_last        (rsp_ch.last),
   .rsp_total_count (rsp_ch.total_count)
);
